[src/fltk_pkg.sv]
// Package for the FNV linear-probe key table: sizes, codes and memory bundles.
// No dependencies; every other file in src uses it by scoped names.
`default_nettype none
package fltk_pkg;

  localparam int MAX_SLOTS_LOG2 = 12;
  localparam int KEY_BYTES      = 6;

  localparam int SLOT_W     = MAX_SLOTS_LOG2;
  localparam int SLOTS      = 1 << MAX_SLOTS_LOG2;
  localparam int PROBE_W    = MAX_SLOTS_LOG2 + 1;
  localparam int KEY_W      = 48;
  localparam int VAL_W      = 8;
  localparam int IVAL_W     = 7;
  localparam int STAT_W     = 3;
  localparam int SLOT_IDX_W = 12;
  localparam int COUNT_W    = 14;
  localparam int LOG2_W     = 4;
  localparam int HASH_W     = 32;
  localparam int HCNT_W     = $clog2(KEY_BYTES + 1);

  localparam logic [COUNT_W-1:0] COUNT_MAX      = {COUNT_W{1'b1}};
  localparam logic [LOG2_W-1:0]  LOG2_RESET     = LOG2_W'(12);
  localparam logic [HASH_W-1:0]  FNV_BASIS      = 32'd2166136261;
  localparam logic [HASH_W-1:0]  FNV_MULTIPLIER = 32'd16777619;
  localparam logic [VAL_W-1:0]   VAL_AMBIG      = {VAL_W{1'b1}};

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_INSERTED  = 3'd0;
  localparam logic [STAT_W-1:0] STAT_REPLACED  = 3'd1;
  localparam logic [STAT_W-1:0] STAT_AMBIGUOUS = 3'd2;
  localparam logic [STAT_W-1:0] STAT_FOUND     = 3'd3;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd4;
  localparam logic [STAT_W-1:0] STAT_FULL      = 3'd5;

  // Request type codes
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_PROBE,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic              rd;
    logic              wr_key;
    logic              wr_v0;
    logic              wr_v1;
    logic [SLOT_W-1:0] addr;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  val;
  } mem_req_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] v0;
    logic [VAL_W-1:0] v1;
  } mem_rd_t;

endpackage
`default_nettype wire

[src/fltk_if.sv]
// Valid/ready channel interfaces for requests and results of the key table.
// Depends on fltk_pkg for field widths.
`default_nettype none
interface fltk_in_if;
  logic                           valid;
  logic                           ready;
  logic                           req_type;
  logic [fltk_pkg::KEY_W-1:0]     key;
  logic                           column;
  logic [fltk_pkg::IVAL_W-1:0]    insert_value;
  logic                           overwrite;

  modport source(output valid, req_type, key, column, insert_value, overwrite,
                 input ready);
  modport sink(input valid, req_type, key, column, insert_value, overwrite,
               output ready);
endinterface

interface fltk_out_if;
  logic                            valid;
  logic                            ready;
  logic [fltk_pkg::STAT_W-1:0]     status;
  logic signed [fltk_pkg::VAL_W-1:0] result_value;
  logic [fltk_pkg::SLOT_IDX_W-1:0] slot_index;
  logic [fltk_pkg::COUNT_W-1:0]    entry_count;

  modport source(output valid, status, result_value, slot_index, entry_count,
                 input ready);
  modport sink(input valid, status, result_value, slot_index, entry_count,
               output ready);
endinterface
`default_nettype wire

[src/fnv_linear_probe_key_table_unit.sv]
// Top level of the FNV-1a linear-probe key table.
// Depends on fltk_pkg, fltk_if, fltk_hash and fltk_store.
//
// Usage:
//   in_ch  : request transfer (req_type, key, column, insert_value, overwrite).
//   out_ch : one result transfer per request (status, result_value,
//            slot_index, entry_count), in request order.
//   cfg_we / cfg_wdata : write slots_log2; write only while the block is idle.
// Timing: the key is hashed one byte per cycle, then the slot
//   memories are probed at one slot per cycle, each probe a registered read
//   followed by the compare. The next request is taken once the result
//   sits in the output register, so one request is in flight at a time.
// Reset: rst_n is synchronous. After reset a clearing pass writes zero to both
//   value columns, one slot per cycle across every slot; in_ch.ready stays low
//   until it finishes. The key memory is not cleared.
// Stall: a result waits in the output register while out_ch.ready is low; the
//   block takes one more request meanwhile and holds its result until the
//   output register frees.
`default_nettype none
module fnv_linear_probe_key_table_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [fltk_pkg::LOG2_W-1:0] cfg_wdata,
  fltk_in_if.sink                          in_ch,
  fltk_out_if.source                       out_ch
);

  fltk_pkg::state_t state_r, state_nxt;

  // configuration
  logic [fltk_pkg::LOG2_W-1:0]  s_log2_r;
  logic [fltk_pkg::LOG2_W-1:0]  used_l2;
  logic [fltk_pkg::PROBE_W-1:0] slots;
  logic [fltk_pkg::SLOT_W-1:0]  mask;

  // clearing pass
  logic [fltk_pkg::SLOT_W-1:0] clr_r, clr_nxt;

  // held request
  logic                         lookup_r;
  logic [fltk_pkg::KEY_W-1:0]   key_r;
  logic                         col_r;
  logic [fltk_pkg::IVAL_W-1:0]  ival_r;
  logic                         over_r;

  // probe
  logic [fltk_pkg::SLOT_W-1:0]  idx_r, idx_nxt;
  logic [fltk_pkg::SLOT_W-1:0]  home_r, home_nxt;
  logic [fltk_pkg::PROBE_W-1:0] n_r, n_nxt;
  logic [fltk_pkg::SLOT_W-1:0]  home_calc;
  logic [fltk_pkg::SLOT_W-1:0]  idx_inc;
  logic [fltk_pkg::PROBE_W-1:0] n_inc;
  logic [fltk_pkg::VAL_W-1:0]   cur_v;
  logic                         is_empty;
  logic                         is_match;
  logic                         wrap_done;

  // result
  logic [fltk_pkg::STAT_W-1:0]  res_status_r, res_status_nxt;
  logic [fltk_pkg::VAL_W-1:0]   res_value_r, res_value_nxt;
  logic [fltk_pkg::SLOT_W-1:0]  res_slot_r, res_slot_nxt;
  logic [fltk_pkg::COUNT_W-1:0] count_r, count_nxt;

  // output register
  logic                          out_valid_r;
  logic [fltk_pkg::STAT_W-1:0]   out_status_r;
  logic [fltk_pkg::VAL_W-1:0]    out_value_r;
  logic [fltk_pkg::SLOT_W-1:0]   out_slot_r;
  logic [fltk_pkg::COUNT_W-1:0]  out_count_r;
  logic                          out_free;
  logic                          out_load;

  logic                          in_accept;
  logic                          hash_start;
  logic                          hash_done;
  logic [fltk_pkg::HASH_W-1:0]   hash;
  fltk_pkg::mem_req_t            mem_req;
  fltk_pkg::mem_rd_t             mem_rd;

  fltk_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hash_start),
    .key   (in_ch.key),
    .done  (hash_done),
    .hash  (hash)
  );

  fltk_store u_store (
    .clk (clk),
    .req (mem_req),
    .rd  (mem_rd)
  );

  // Clamp the slot count to 1..MAX_SLOTS_LOG2 bits.
  always_comb begin
    if (s_log2_r == '0) begin
      used_l2 = fltk_pkg::LOG2_W'(1);
    end else if (int'(s_log2_r) > fltk_pkg::MAX_SLOTS_LOG2) begin
      used_l2 = fltk_pkg::LOG2_W'(fltk_pkg::MAX_SLOTS_LOG2);
    end else begin
      used_l2 = s_log2_r;
    end
  end

  assign slots     = fltk_pkg::PROBE_W'(1) << used_l2;
  assign mask      = fltk_pkg::SLOT_W'(slots - 1'b1);
  assign home_calc = fltk_pkg::SLOT_W'(hash) & mask;

  // Compare on the slot read in the previous cycle.
  assign cur_v     = col_r ? mem_rd.v1 : mem_rd.v0;
  assign is_empty  = (cur_v == '0);
  assign is_match  = (mem_rd.key == key_r);
  assign idx_inc   = (idx_r + 1'b1) & mask;
  assign n_inc     = n_r + 1'b1;
  assign wrap_done = (n_inc == slots);

  assign in_accept = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid_r || out_ch.ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fltk_pkg::ST_CLEAR: begin
        if (clr_r == '1) begin
          state_nxt = fltk_pkg::ST_IDLE;
        end
      end
      fltk_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_nxt = fltk_pkg::ST_HASH;
        end
      end
      fltk_pkg::ST_HASH: begin
        if (hash_done) begin
          state_nxt = fltk_pkg::ST_PROBE;
        end
      end
      fltk_pkg::ST_PROBE: begin
        if (is_empty || is_match || wrap_done) begin
          state_nxt = fltk_pkg::ST_RESP;
        end
      end
      fltk_pkg::ST_RESP: begin
        if (out_free) begin
          state_nxt = fltk_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fltk_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath updates
  always_comb begin
    in_ch.ready    = 1'b0;
    hash_start     = 1'b0;
    out_load       = 1'b0;
    clr_nxt        = clr_r;
    idx_nxt        = idx_r;
    home_nxt       = home_r;
    n_nxt          = n_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    res_slot_nxt   = res_slot_r;
    count_nxt      = count_r;
    mem_req        = '0;
    mem_req.addr   = idx_r;
    mem_req.key    = key_r;
    mem_req.val    = fltk_pkg::VAL_W'(ival_r);
    case (state_r)
      fltk_pkg::ST_CLEAR: begin
        // sweep both value columns to zero
        mem_req.wr_v0 = 1'b1;
        mem_req.wr_v1 = 1'b1;
        mem_req.addr  = clr_r;
        mem_req.val   = '0;
        clr_nxt       = clr_r + 1'b1;
      end
      fltk_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        hash_start  = in_ch.valid;
      end
      fltk_pkg::ST_HASH: begin
        if (hash_done) begin
          // issue the read of the home slot
          idx_nxt      = home_calc;
          home_nxt     = home_calc;
          n_nxt        = '0;
          mem_req.rd   = 1'b1;
          mem_req.addr = home_calc;
        end
      end
      fltk_pkg::ST_PROBE: begin
        res_slot_nxt = idx_r;
        if (is_empty) begin
          if (lookup_r == fltk_pkg::REQ_LOOKUP) begin
            res_status_nxt = fltk_pkg::STAT_NOT_FOUND;
            res_value_nxt  = '0;
          end else begin
            // new entry: write key and value, bump the saturating count
            mem_req.wr_key = 1'b1;
            mem_req.wr_v0  = !col_r;
            mem_req.wr_v1  = col_r;
            res_status_nxt = fltk_pkg::STAT_INSERTED;
            res_value_nxt  = fltk_pkg::VAL_W'(ival_r);
            if (count_r != fltk_pkg::COUNT_MAX) begin
              count_nxt = count_r + 1'b1;
            end
          end
        end else if (is_match) begin
          if (lookup_r == fltk_pkg::REQ_LOOKUP) begin
            res_status_nxt = fltk_pkg::STAT_FOUND;
            res_value_nxt  = cur_v;
          end else begin
            mem_req.wr_v0 = !col_r;
            mem_req.wr_v1 = col_r;
            if (over_r) begin
              res_status_nxt = fltk_pkg::STAT_REPLACED;
              res_value_nxt  = fltk_pkg::VAL_W'(ival_r);
            end else begin
              mem_req.val    = fltk_pkg::VAL_AMBIG;
              res_status_nxt = fltk_pkg::STAT_AMBIGUOUS;
              res_value_nxt  = fltk_pkg::VAL_AMBIG;
            end
          end
        end else if (wrap_done) begin
          // full pass without a hit: report full at the home slot
          res_status_nxt = fltk_pkg::STAT_FULL;
          res_value_nxt  = '0;
          res_slot_nxt   = home_r;
        end else begin
          // advance to the next slot, wrapping within the slots in use
          idx_nxt      = idx_inc;
          n_nxt        = n_inc;
          mem_req.rd   = 1'b1;
          mem_req.addr = idx_inc;
        end
      end
      fltk_pkg::ST_RESP: begin
        out_load = out_free;
      end
      default: begin
        in_ch.ready = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fltk_pkg::ST_CLEAR;
      clr_r       <= '0;
      count_r     <= '0;
      s_log2_r    <= fltk_pkg::LOG2_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      count_r <= count_nxt;
      if (cfg_we) begin
        s_log2_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      lookup_r <= in_ch.req_type;
      key_r    <= in_ch.key;
      col_r    <= in_ch.column;
      ival_r   <= in_ch.insert_value;
      over_r   <= in_ch.overwrite;
    end
    idx_r        <= idx_nxt;
    home_r       <= home_nxt;
    n_r          <= n_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    res_slot_r   <= res_slot_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_value_r  <= res_value_r;
      out_slot_r   <= res_slot_r;
      out_count_r  <= count_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.result_value = out_value_r;
  assign out_ch.slot_index   = fltk_pkg::SLOT_IDX_W'(out_slot_r);
  assign out_ch.entry_count  = out_count_r;

  // Value memories are written only by the clearing pass or a resolved probe.
  a_wr_source: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_req.wr_v0 || mem_req.wr_v1) |->
      (state_r == fltk_pkg::ST_CLEAR || state_r == fltk_pkg::ST_PROBE))
    else $error("value write outside clear or probe");

  // The probe never runs past one full pass over the slots in use.
  a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fltk_pkg::ST_PROBE) |-> (n_r < slots))
    else $error("probe count beyond slot count");

  // A waiting result is not overwritten by the next request.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=>
      (out_valid_r && $stable(out_slot_r) && $stable(out_status_r)))
    else $error("stalled result changed");

  // The hash unit finishes only while the controller waits for it.
  a_hash_sync: assert property (@(posedge clk) disable iff (!rst_n)
    hash_done |-> (state_r == fltk_pkg::ST_HASH))
    else $error("hash done outside hash wait");

  // The entry count never goes down.
  a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (count_r >= $past(count_r)))
    else $error("entry count decreased");

endmodule
`default_nettype wire

[src/fltk_hash.sv]
// Iterative 32-bit FNV-1a hash unit: one key byte per cycle.
// Depends on fltk_pkg.
`default_nettype none
module fltk_hash (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [fltk_pkg::KEY_W-1:0]    key,
  output logic                               done,
  output logic [fltk_pkg::HASH_W-1:0]        hash
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [fltk_pkg::HCNT_W-1:0]   cnt_r, cnt_nxt;
  logic [fltk_pkg::KEY_W-1:0]    sh_r, sh_nxt;
  logic [fltk_pkg::HASH_W-1:0]   h_r, h_nxt;
  logic [fltk_pkg::HASH_W-1:0]   mixed;

  // xor in the low byte, then multiply by the FNV multiplier (product truncated)
  assign mixed = h_r ^ fltk_pkg::HASH_W'(sh_r[7:0]);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    sh_nxt   = sh_r;
    h_nxt    = h_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      sh_nxt   = key;
      h_nxt    = fltk_pkg::FNV_BASIS;
    end else if (busy_r) begin
      h_nxt   = fltk_pkg::HASH_W'(mixed * fltk_pkg::FNV_MULTIPLIER);
      sh_nxt  = sh_r >> 8;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == fltk_pkg::HCNT_W'(fltk_pkg::KEY_BYTES - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    sh_r  <= sh_nxt;
    h_r   <= h_nxt;
  end

  assign done = done_r;
  assign hash = h_r;

endmodule
`default_nettype wire

[src/fltk_store.sv]
// Slot storage: key memory plus the two value-column memories, with registered reads.
// Depends on fltk_pkg for the request and read-data bundles.
`default_nettype none
module fltk_store (
  input  wire logic               clk,
  input  wire fltk_pkg::mem_req_t req,
  output fltk_pkg::mem_rd_t       rd
);

  logic [fltk_pkg::KEY_W-1:0] key_mem [fltk_pkg::SLOTS];
  logic [fltk_pkg::VAL_W-1:0] v0_mem  [fltk_pkg::SLOTS];
  logic [fltk_pkg::VAL_W-1:0] v1_mem  [fltk_pkg::SLOTS];

  always_ff @(posedge clk) begin
    if (req.wr_key) begin
      key_mem[req.addr] <= req.key;
    end
    if (req.wr_v0) begin
      v0_mem[req.addr] <= req.val;
    end
    if (req.wr_v1) begin
      v1_mem[req.addr] <= req.val;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd) begin
      rd.key <= key_mem[req.addr];
      rd.v0  <= v0_mem[req.addr];
      rd.v1  <= v1_mem[req.addr];
    end
  end

endmodule
`default_nettype wire
